### hw/rtl/tat_pkg.sv
// ----------------------------------------------------------------------------
// Thermistor conversion package
// Shared widths, resistance table, segment deltas and control types for the
// thermistor ADC to temperature pipeline.
// ----------------------------------------------------------------------------
package tat_pkg;

    localparam int TAT_AD_W      = 12;  // ADC sample
    localparam int TAT_TEMP_W    = 15;  // temperature in 0.01 C, signed
    localparam int TAT_POINTS    = 25;  // table points, 5 C apart
    localparam int TAT_SEGS      = TAT_POINTS - 1;
    localparam int TAT_SEG_W     = 5;
    localparam int TAT_RES_W     = 21;  // table entry, 0.1 ohm
    localparam int TAT_DELTA_W   = 19;  // entry minus next entry
    localparam int TAT_LHS_W     = 29;  // 100000 * ad
    localparam int TAT_PROD_W    = 33;  // entry * d
    localparam int TAT_DEN_W     = 31;  // delta * d
    localparam int TAT_REM_W     = 40;  // divider partial remainder
    localparam int TAT_DSH_W     = TAT_DEN_W + 8;
    localparam int TAT_Q_W       = 9;   // fraction 0..500

    localparam logic [TAT_AD_W-1:0]  TAT_AD_FULL   = 12'd4095;
    localparam logic [16:0]          TAT_R_REF_X10 = 17'd100000;
    localparam logic [8:0]           TAT_T_STEP    = 9'd500;
    localparam logic signed [TAT_TEMP_W-1:0] TAT_T_LOW  = -15'sd2000;
    localparam logic signed [TAT_TEMP_W-1:0] TAT_T_HIGH = 15'sd10000;

    // Thermistor resistance in 0.1 ohm, one point per 5 C from -20 C to 100 C
    localparam logic [TAT_RES_W-1:0] TAT_RES_X10 [TAT_POINTS] = '{
        21'd1146600, 21'd845100, 21'd629270, 21'd470770, 21'd355630,
        21'd271190,  21'd208600, 21'd162040, 21'd126830, 21'd100000,
        21'd79420,   21'd63270,  21'd50740,  21'd41030,  21'd33360,
        21'd27240,   21'd22370,  21'd18460,  21'd15300,  21'd12750,
        21'd10680,   21'd8993,   21'd7607,   21'd6452,   21'd5494
    };

    // Width of each segment in resistance, entry i minus entry i+1
    localparam logic [TAT_DELTA_W-1:0] TAT_DELTA [TAT_SEGS] = '{
        19'd301500, 19'd215830, 19'd158500, 19'd115140, 19'd84440,
        19'd62590,  19'd46560,  19'd35210,  19'd26830,  19'd20580,
        19'd16150,  19'd12530,  19'd9710,   19'd7670,   19'd6120,
        19'd4870,   19'd3910,   19'd3160,   19'd2550,   19'd2070,
        19'd1687,   19'd1386,   19'd1155,   19'd958
    };

    typedef enum logic [1:0] {
        TAT_KIND_SEG  = 2'd0,   // interpolate inside a segment
        TAT_KIND_LOW  = 2'd1,   // clamp to -20 C
        TAT_KIND_HIGH = 2'd2    // clamp to 100 C
    } tat_kind_t;

    typedef struct packed {
        tat_kind_t              kind;
        logic [TAT_SEG_W-1:0]   seg;
    } tat_ctl_t;

endpackage

### hw/rtl/tat_seg_find.sv
// ----------------------------------------------------------------------------
// Segment finder
// Compares the sample against per-entry ADC thresholds and registers the
// clamp decision, the segment index and the divider span d = 4095 - ad.
// ----------------------------------------------------------------------------
module tat_seg_find (
    input  logic                            aclk,
    input  logic                            en,
    input  logic [tat_pkg::TAT_AD_W-1:0]    ad_value,
    output tat_pkg::tat_ctl_t               ctl_o,
    output logic [tat_pkg::TAT_AD_W-1:0]    d_o,
    output logic [tat_pkg::TAT_AD_W-1:0]    ad_o
);

    logic [tat_pkg::TAT_POINTS-1:0] le;   // R at or below entry
    logic [tat_pkg::TAT_POINTS-1:0] ge;   // R at or above entry
    tat_pkg::tat_ctl_t              ctl_next;
    tat_pkg::tat_ctl_t              ctl_reg;
    logic [tat_pkg::TAT_AD_W-1:0]   d_reg;
    logic [tat_pkg::TAT_AD_W-1:0]   ad_reg;
    logic                           found;

    // R vs entry T reduces to ad vs 4095*T/(100000+T), floored or ceiled
    for (genvar i = 0; i < tat_pkg::TAT_POINTS; i++) begin : g_thr
        localparam logic [63:0] PROD = 64'(tat_pkg::TAT_AD_FULL)
                                     * 64'(tat_pkg::TAT_RES_X10[i]);
        localparam logic [63:0] SUM  = 64'(tat_pkg::TAT_R_REF_X10)
                                     + 64'(tat_pkg::TAT_RES_X10[i]);
        localparam logic [tat_pkg::TAT_AD_W-1:0] FLR = 12'(PROD / SUM);
        localparam logic [tat_pkg::TAT_AD_W-1:0] CEL = 12'((PROD + SUM - 64'd1) / SUM);
        assign le[i] = (ad_value <= FLR);
        assign ge[i] = (ad_value >= CEL);
    end

    always_comb begin
        ctl_next.kind = tat_pkg::TAT_KIND_SEG;
        ctl_next.seg  = 5'(tat_pkg::TAT_SEGS - 1);
        found         = 1'b0;
        for (int i = 0; i < tat_pkg::TAT_SEGS; i++) begin
            if (!found && le[i] && ge[i+1]) begin
                ctl_next.seg = 5'(i);
                found        = 1'b1;
            end
        end
        priority if (ad_value == tat_pkg::TAT_AD_FULL || ge[0]) begin
            ctl_next.kind = tat_pkg::TAT_KIND_LOW;
        end else if (le[tat_pkg::TAT_POINTS-1]) begin
            ctl_next.kind = tat_pkg::TAT_KIND_HIGH;
        end else begin
            ctl_next.kind = tat_pkg::TAT_KIND_SEG;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl_reg <= ctl_next;
            d_reg   <= tat_pkg::TAT_AD_FULL - ad_value;
            ad_reg  <= ad_value;
        end
    end

    assign ctl_o = ctl_reg;
    assign d_o   = d_reg;
    assign ad_o  = ad_reg;

endmodule

### hw/rtl/tat_interp_prep.sv
// ----------------------------------------------------------------------------
// Interpolation setup
// Three stages: table products, numerator difference, scaling by 500 and
// alignment of the divisor for the bit-serial divider.
// ----------------------------------------------------------------------------
module tat_interp_prep (
    input  logic                            aclk,
    input  logic [2:0]                      en,
    input  tat_pkg::tat_ctl_t               ctl_i,
    input  logic [tat_pkg::TAT_AD_W-1:0]    d_i,
    input  logic [tat_pkg::TAT_AD_W-1:0]    ad_i,
    output tat_pkg::tat_ctl_t               ctl_o,
    output logic [tat_pkg::TAT_REM_W-1:0]   rem_o,
    output logic [tat_pkg::TAT_DSH_W-1:0]   dsh_o
);

    tat_pkg::tat_ctl_t                  ctl2_reg, ctl3_reg, ctl4_reg;
    logic [tat_pkg::TAT_PROD_W-1:0]     prod_reg;
    logic [tat_pkg::TAT_DEN_W-1:0]      den2_reg, den3_reg;
    logic [tat_pkg::TAT_LHS_W-1:0]      lhs_reg;
    logic [tat_pkg::TAT_DEN_W-1:0]      num_reg;
    logic [tat_pkg::TAT_REM_W-1:0]      rem_reg;
    logic [tat_pkg::TAT_DSH_W-1:0]      dsh_reg;
    logic [tat_pkg::TAT_PROD_W-1:0]     prod_next;
    logic [tat_pkg::TAT_DEN_W-1:0]      den_next;
    logic [tat_pkg::TAT_LHS_W-1:0]      lhs_next;
    logic [tat_pkg::TAT_PROD_W-1:0]     diff;
    logic [tat_pkg::TAT_DEN_W-1:0]      num_next;
    logic [tat_pkg::TAT_REM_W-1:0]      rem_next;

    always_comb begin
        prod_next = 33'(tat_pkg::TAT_RES_X10[ctl_i.seg]) * 33'(d_i);
        den_next  = 31'(tat_pkg::TAT_DELTA[ctl_i.seg[4:0] > 5'(tat_pkg::TAT_SEGS - 1)
                        ? 5'(tat_pkg::TAT_SEGS - 1) : ctl_i.seg]) * 31'(d_i);
        lhs_next  = 29'(tat_pkg::TAT_R_REF_X10) * 29'(ad_i);
    end

    // Numerator is never negative inside a segment; floor at zero otherwise
    always_comb begin
        diff     = prod_reg - 33'(lhs_reg);
        num_next = (prod_reg >= 33'(lhs_reg)) ? diff[tat_pkg::TAT_DEN_W-1:0] : '0;
    end

    // 500 = 512 - 8 - 4
    assign rem_next = (40'(num_reg) << 9) - (40'(num_reg) << 3) - (40'(num_reg) << 2);

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            ctl2_reg <= ctl_i;
            prod_reg <= prod_next;
            den2_reg <= den_next;
            lhs_reg  <= lhs_next;
        end
        if (en[1]) begin
            ctl3_reg <= ctl2_reg;
            num_reg  <= num_next;
            den3_reg <= den2_reg;
        end
        if (en[2]) begin
            ctl4_reg <= ctl3_reg;
            rem_reg  <= rem_next;
            dsh_reg  <= {den3_reg, 8'd0};
        end
    end

    assign ctl_o = ctl4_reg;
    assign rem_o = rem_reg;
    assign dsh_o = dsh_reg;

endmodule

### hw/rtl/tat_div_stage.sv
// ----------------------------------------------------------------------------
// Divider stage
// One restoring step: subtract the aligned divisor when it fits, shift the
// remainder left and append one quotient bit.
// ----------------------------------------------------------------------------
module tat_div_stage (
    input  logic                            aclk,
    input  logic                            en,
    input  tat_pkg::tat_ctl_t               ctl_i,
    input  logic [tat_pkg::TAT_REM_W-1:0]   rem_i,
    input  logic [tat_pkg::TAT_DSH_W-1:0]   dsh_i,
    input  logic [tat_pkg::TAT_Q_W-1:0]     q_i,
    output tat_pkg::tat_ctl_t               ctl_o,
    output logic [tat_pkg::TAT_REM_W-1:0]   rem_o,
    output logic [tat_pkg::TAT_DSH_W-1:0]   dsh_o,
    output logic [tat_pkg::TAT_Q_W-1:0]     q_o
);

    tat_pkg::tat_ctl_t                  ctl_reg;
    logic [tat_pkg::TAT_REM_W-1:0]      rem_reg, rem_next, rem_sub;
    logic [tat_pkg::TAT_DSH_W-1:0]      dsh_reg;
    logic [tat_pkg::TAT_Q_W-1:0]        q_reg;
    logic                               fits;

    always_comb begin
        fits     = (rem_i >= 40'(dsh_i));
        rem_sub  = fits ? (rem_i - 40'(dsh_i)) : rem_i;
        rem_next = {rem_sub[tat_pkg::TAT_REM_W-2:0], 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl_reg <= ctl_i;
            rem_reg <= rem_next;
            dsh_reg <= dsh_i;
            q_reg   <= {q_i[tat_pkg::TAT_Q_W-2:0], fits};
        end
    end

    assign ctl_o = ctl_reg;
    assign rem_o = rem_reg;
    assign dsh_o = dsh_reg;
    assign q_o   = q_reg;

endmodule

### hw/rtl/tat_result.sv
// ----------------------------------------------------------------------------
// Result stage
// Adds the segment base temperature to the fraction, or applies a clamp,
// and holds the result for the output channel.
// ----------------------------------------------------------------------------
module tat_result (
    input  logic                                aclk,
    input  logic                                en,
    input  tat_pkg::tat_ctl_t                   ctl_i,
    input  logic [tat_pkg::TAT_Q_W-1:0]         q_i,
    output logic signed [tat_pkg::TAT_TEMP_W-1:0] temp_o
);

    logic signed [tat_pkg::TAT_TEMP_W-1:0] temp_reg, temp_next, base;

    always_comb begin
        base = tat_pkg::TAT_T_LOW
             + $signed(15'(ctl_i.seg) * 15'(tat_pkg::TAT_T_STEP));
        unique case (ctl_i.kind)
            tat_pkg::TAT_KIND_SEG:  temp_next = base + $signed(15'(q_i));
            tat_pkg::TAT_KIND_LOW:  temp_next = tat_pkg::TAT_T_LOW;
            tat_pkg::TAT_KIND_HIGH: temp_next = tat_pkg::TAT_T_HIGH;
            default:                temp_next = tat_pkg::TAT_T_LOW;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            temp_reg <= temp_next;
        end
    end

    assign temp_o = temp_reg;

endmodule

### hw/rtl/thermistor_adc_to_temperature.sv
// ----------------------------------------------------------------------------
// Thermistor ADC to temperature
// Converts a 12-bit thermistor divider sample into degrees C times 100.
//
// Input channel s_valid/s_ready carries s_ad_value, the raw ADC reading.
// Output channel m_valid/m_ready carries m_temperature_centi, a signed
// 15-bit temperature in 0.01 C, clamped to -2000..10000.
// Each accepted item yields exactly one result item, in order.
// Depth: 14 register stages (1 segment search, 3 setup stages, 9 divider
// stages, 1 result).
// Throughput: one item per cycle while s_ready is high; the nine-stage
// bit-serial divider for the interpolation fraction sets the depth, and
// every stage takes a new item.
// Each stage has its own valid bit and takes an item when it is empty or
// its successor moves on, so bubbles collapse and s_ready stays high while
// any stage is empty, even with a result waiting on m_ready.
// When the receiver stalls, items stack up; s_ready drops only once all
// fourteen stages hold an item. Nothing is dropped or repeated.
// Reset (aresetn low, synchronous) empties the pipeline; the payload
// registers are not reset and there is no configuration.
// ----------------------------------------------------------------------------
module thermistor_adc_to_temperature (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [tat_pkg::TAT_AD_W-1:0]            s_ad_value,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [tat_pkg::TAT_TEMP_W-1:0]   m_temperature_centi
);

    localparam int NSTAGE  = 14;
    localparam int DIV0    = 4;     // first divider stage
    localparam int NDIV    = tat_pkg::TAT_Q_W;
    localparam int RES_STG = NSTAGE - 1;

    // Stage valid bits and per-stage load enables
    logic [NSTAGE-1:0]  vld_reg;
    logic [NSTAGE-1:0]  vld_next;
    logic [NSTAGE:0]    rdy;

    // Stage payload wiring
    tat_pkg::tat_ctl_t                  seg_ctl;
    logic [tat_pkg::TAT_AD_W-1:0]       seg_d, seg_ad;
    tat_pkg::tat_ctl_t                  div_ctl [NDIV+1];
    logic [tat_pkg::TAT_REM_W-1:0]      div_rem [NDIV+1];
    logic [tat_pkg::TAT_DSH_W-1:0]      div_dsh [NDIV+1];
    logic [tat_pkg::TAT_Q_W-1:0]        div_q   [NDIV+1];

    // A stage loads when it is empty or its contents move on
    always_comb begin
        rdy[NSTAGE] = m_ready;
        for (int k = NSTAGE - 1; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    // Advance valid bits with the data
    always_comb begin
        vld_next = vld_reg;
        if (rdy[0]) begin
            vld_next[0] = s_valid;
        end
        for (int k = 1; k < NSTAGE; k++) begin
            if (rdy[k]) begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_ready = rdy[0];
    assign m_valid = vld_reg[RES_STG];

    tat_seg_find u_seg_find (
        .aclk     (aclk),
        .en       (rdy[0]),
        .ad_value (s_ad_value),
        .ctl_o    (seg_ctl),
        .d_o      (seg_d),
        .ad_o     (seg_ad)
    );

    tat_interp_prep u_interp_prep (
        .aclk  (aclk),
        .en    (rdy[3:1]),
        .ctl_i (seg_ctl),
        .d_i   (seg_d),
        .ad_i  (seg_ad),
        .ctl_o (div_ctl[0]),
        .rem_o (div_rem[0]),
        .dsh_o (div_dsh[0])
    );

    assign div_q[0] = '0;

    // One quotient bit per stage, most significant first
    for (genvar j = 0; j < NDIV; j++) begin : g_div
        tat_div_stage u_div_stage (
            .aclk  (aclk),
            .en    (rdy[DIV0+j]),
            .ctl_i (div_ctl[j]),
            .rem_i (div_rem[j]),
            .dsh_i (div_dsh[j]),
            .q_i   (div_q[j]),
            .ctl_o (div_ctl[j+1]),
            .rem_o (div_rem[j+1]),
            .dsh_o (div_dsh[j+1]),
            .q_o   (div_q[j+1])
        );
    end

    tat_result u_result (
        .aclk   (aclk),
        .en     (rdy[RES_STG]),
        .ctl_i  (div_ctl[NDIV]),
        .q_i    (div_q[NDIV]),
        .temp_o (m_temperature_centi)
    );

    // Results always fall inside the clamp range
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_temperature_centi >= tat_pkg::TAT_T_LOW
                     && m_temperature_centi <= tat_pkg::TAT_T_HIGH))
        else $error("temperature out of clamp range");

    // Full-scale sample is classified as the low clamp
    a_full_scale: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_ad_value == tat_pkg::TAT_AD_FULL)
        |=> seg_ctl.kind == tat_pkg::TAT_KIND_LOW)
        else $error("full-scale sample not clamped low");

    // Input backpressure only when every stage holds an item
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> &vld_reg)
        else $error("input stalled with an empty stage");

    // Interpolation fraction never exceeds one step
    a_frac_max: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[RES_STG-1] && div_ctl[NDIV].kind == tat_pkg::TAT_KIND_SEG)
        |-> div_q[NDIV] <= tat_pkg::TAT_T_STEP)
        else $error("interpolation fraction above one step");

endmodule

### dv/thermistor_adc_to_temperature_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermistor ADC to temperature testbench
// Feeds raw ADC samples into the converter and checks each temperature
// against a bit-exact integer predictor of the table interpolation.
// Covers both clamps, every table segment and random handshake gaps.
// ----------------------------------------------------------------------------
module thermistor_adc_to_temperature_tb;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_ITEMS = 650;
    localparam int DRAIN_CYCLES = 40;    // pipeline is 14 deep, leave margin
    localparam int STALL_LIMIT  = 5000;  // cycles with no item moved
    localparam int IDLE_PCT     = 7;
    localparam int QUIET_FIRST  = 250;   // accepted-item window with no idling
    localparam int QUIET_LAST   = 450;
    localparam int REPORT_MAX   = 10;

    localparam int                  TABLE_PTS = 25;
    localparam logic [11:0]         AD_FULL   = 12'd4095;
    localparam longint unsigned     REF_X10   = 64'd100000;
    localparam int                  STEP_C    = 500;
    localparam logic signed [14:0]  CLAMP_LO  = -15'sd2000;
    localparam logic signed [14:0]  CLAMP_HI  = 15'sd10000;

    // Thermistor resistance in 0.1 ohm, -20 C to 100 C in 5 C steps
    localparam longint unsigned RES_X10 [TABLE_PTS] = '{
        1146600, 845100, 629270, 470770, 355630, 271190, 208600,
        162040, 126830, 100000, 79420, 63270, 50740, 41030, 33360,
        27240, 22370, 18460, 15300, 12750, 10680, 8993, 7607,
        6452, 5494
    };

    logic                                   aclk    = 1'b0;
    logic                                   aresetn = 1'b0;
    logic                                   s_valid = 1'b0;
    logic                                   s_ready;
    logic [tat_pkg::TAT_AD_W-1:0]           s_ad_value = '0;
    logic                                   m_valid;
    logic                                   m_ready = 1'b0;
    logic signed [tat_pkg::TAT_TEMP_W-1:0]  m_temperature_centi;

    logic [tat_pkg::TAT_AD_W-1:0]           ad_pending_q [$];
    logic signed [tat_pkg::TAT_TEMP_W-1:0]  temp_expect_q [$];

    logic   in_fire = 1'b0;     // item taken on the input at the last edge
    int     in_count = 0;
    int     out_count = 0;
    int     low_count = 0;
    int     high_count = 0;
    int     error_count = 0;
    int     stall_cycles = 0;

    thermistor_adc_to_temperature dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_ad_value          (s_ad_value),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_temperature_centi (m_temperature_centi)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // Predict the temperature of one sample. Resistance is never divided out:
    // 10*R = 100000*ad/d is compared with a table entry T as 100000*ad vs T*d,
    // and the fraction inside a segment is floored exactly.
    function automatic logic signed [14:0] adc_to_centi(input logic [11:0] ad);
        longint unsigned span;
        longint unsigned scaled_r;
        longint unsigned gap;
        longint unsigned den;
        int seg;
        int centi;
        if (ad == AD_FULL)
            return CLAMP_LO;
        span     = 64'(AD_FULL - ad);
        scaled_r = REF_X10 * 64'(ad);
        if (scaled_r >= RES_X10[0] * span)
            return CLAMP_LO;
        if (scaled_r <= RES_X10[TABLE_PTS-1] * span)
            return CLAMP_HI;
        // Take the lower-index segment when the resistance sits on an entry
        seg = TABLE_PTS - 2;
        for (int i = 0; i < TABLE_PTS - 1; i++) begin
            if (scaled_r <= RES_X10[i] * span && scaled_r >= RES_X10[i+1] * span) begin
                seg = i;
                break;
            end
        end
        gap   = RES_X10[seg] * span;
        gap   = (gap >= scaled_r) ? gap - scaled_r : 64'd0;
        den   = span * (RES_X10[seg] - RES_X10[seg+1]);
        centi = int'(CLAMP_LO) + STEP_C * seg + int'((64'(STEP_C) * gap) / den);
        return 15'(centi);
    endfunction

    // Random idling on both sides, except inside the quiet window
    function automatic bit take_idle();
        if (in_count >= QUIET_FIRST && in_count < QUIET_LAST)
            return 1'b0;
        return $urandom_range(99) < IDLE_PCT;
    endfunction

    // Driver: change inputs on the falling edge only. Advance to the next
    // sample once the current one was taken, otherwise hold it.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            if (!s_valid || in_fire) begin
                if (ad_pending_q.size() != 0 && !take_idle()) begin
                    s_valid    <= 1'b1;
                    s_ad_value <= ad_pending_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= !take_idle();
        end
    end

    // Monitor: sample both channels on the rising edge. Record the input
    // item first so a same-edge result would still find its expectation.
    always @(posedge aclk) begin
        if (!aresetn) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                temp_expect_q.push_back(adc_to_centi(s_ad_value));
                in_count <= in_count + 1;
            end
            if (m_valid && m_ready) begin
                out_count <= out_count + 1;
                if (m_temperature_centi == CLAMP_LO)
                    low_count <= low_count + 1;
                if (m_temperature_centi == CLAMP_HI)
                    high_count <= high_count + 1;
                if (temp_expect_q.size() == 0) begin
                    if (error_count < REPORT_MAX)
                        $display("result %0d arrived with nothing outstanding: %0d",
                                 out_count, m_temperature_centi);
                    error_count <= error_count + 1;
                end else begin
                    logic signed [14:0] want;
                    want = temp_expect_q.pop_front();
                    if (m_temperature_centi !== want) begin
                        if (error_count < REPORT_MAX)
                            $display("result %0d temperature_centi: expected %0d, got %0d",
                                     out_count, want, m_temperature_centi);
                        error_count <= error_count + 1;
                    end
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves on either channel for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        int exact_hits;
        logic [11:0] ad;
        longint unsigned edge_ad;

        // Directed: both rails, both clamp boundaries, checkerboard bits
        ad_pending_q.push_back(12'd0);
        ad_pending_q.push_back(12'd1);
        ad_pending_q.push_back(12'd213);
        ad_pending_q.push_back(12'd214);
        ad_pending_q.push_back(12'd3766);
        ad_pending_q.push_back(12'd3767);
        ad_pending_q.push_back(12'd4094);
        ad_pending_q.push_back(AD_FULL);
        ad_pending_q.push_back(12'h555);
        ad_pending_q.push_back(12'hAAA);

        // Land next to every other inner table entry, from just below it
        for (int i = 1; i < TABLE_PTS - 1; i += 2) begin
            edge_ad = (RES_X10[i] * 64'd4095) / (REF_X10 + RES_X10[i]);
            ad_pending_q.push_back(12'(edge_ad));
        end

        // Add samples whose resistance equals an inner entry exactly
        exact_hits = 0;
        for (int a = 1; a < 4095 && exact_hits < 3; a++) begin
            for (int i = 1; i < TABLE_PTS - 1; i++) begin
                if (REF_X10 * 64'(a) == RES_X10[i] * 64'(4095 - a)) begin
                    ad_pending_q.push_back(12'(a));
                    exact_hits++;
                end
            end
        end

        // Random: mostly inside the table span, the rest across the full range
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(99) < 80)
                ad = 12'($urandom_range(3766, 214));
            else
                ad = 12'($urandom_range(4095, 0));
            ad_pending_q.push_back(ad);
        end

        // Hold reset, then release on a falling edge
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        // Drain: wait for the input side, then for every result, then idle out
        while (ad_pending_q.size() != 0 || s_valid)
            @(posedge aclk);
        while (temp_expect_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("converted %0d samples into %0d temperatures", in_count, out_count);
        $display("%0d clamped to -20 C, %0d clamped to 100 C, %0d mismatches",
                 low_count, high_count, error_count);
        if (error_count == 0 && temp_expect_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/tat_pkg.sv
hw/rtl/tat_seg_find.sv
hw/rtl/tat_interp_prep.sv
hw/rtl/tat_div_stage.sv
hw/rtl/tat_result.sv
hw/rtl/thermistor_adc_to_temperature.sv
dv/thermistor_adc_to_temperature_tb.sv
